### rtl/wsurl_pkg.sv
// Shared types and constants for the WebSocket URL checker.
package wsurl_pkg;

  localparam int MAX_URL_LEN_DEF  = 2048;
  localparam int MAX_HOST_LEN_DEF = 255;

  localparam logic [15:0] PORT_DEFAULT_WS  = 16'd80;
  localparam logic [15:0] PORT_DEFAULT_WSS = 16'd443;
  localparam logic [16:0] PORT_MAX         = 17'd65535;

  typedef enum logic [3:0] {
    STATUS_OK       = 4'd0,
    STATUS_EMPTY    = 4'd1,
    STATUS_TOO_LONG = 4'd2,
    STATUS_SCHEME   = 4'd3,
    STATUS_NO_HOST  = 4'd4,
    STATUS_FRAGMENT = 4'd5,
    STATUS_PORT     = 4'd6,
    STATUS_BRACKETS = 4'd7,
    STATUS_JUNK     = 4'd8,
    STATUS_BAD_HOST = 4'd9
  } status_e;

  typedef enum logic [1:0] {
    SCHEME_MATCH = 2'd0,
    SCHEME_DONE  = 2'd1,
    SCHEME_FAIL  = 2'd2
  } scheme_e;

  typedef enum logic [1:0] {
    BR_NONE    = 2'd0,
    BR_PENDING = 2'd1,
    BR_COLON   = 2'd2,
    BR_OTHER   = 2'd3
  } bracket_e;

  typedef struct packed {
    logic [7:0] url_char;
    logic       has_char;
    logic       last_char;
  } in_beat_t;

  typedef struct packed {
    status_e     status;
    logic        use_tls;
    logic [15:0] port_number;
    logic [11:0] host_offset;
    logic [7:0]  host_length;
    logic        path_given;
    logic [11:0] path_offset;
    logic [11:0] path_length;
  } out_beat_t;

endpackage

### rtl/wsurl_core.sv
// URL scan state, per-byte update and final verdict logic.
module wsurl_core #(
  parameter int MAX_URL_LEN  = wsurl_pkg::MAX_URL_LEN_DEF,
  parameter int MAX_HOST_LEN = wsurl_pkg::MAX_HOST_LEN_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  wsurl_pkg::in_beat_t  beat_i,
  output wsurl_pkg::out_beat_t verdict_o
);

  // counter holds MAX_URL_LEN + 1 when saturated
  localparam int CW = $clog2(MAX_URL_LEN + 2);

  localparam logic [2:0] PORT_CNT_MAX  = 3'd5;
  localparam logic [2:0] PORT_CNT_OVER = 3'd6;
  localparam logic [2:0] PORT_CNT_BAD  = 3'd7;

  typedef struct packed {
    logic [CW-1:0]        cnt;
    wsurl_pkg::scheme_e   scheme;
    logic                 tls;
    logic                 in_path;
    logic                 frag;
    logic                 colon;
    logic [CW-1:0]        auth_len;
    logic [CW-1:0]        last_colon;
    logic                 bad_before;
    logic                 bad_any;
    logic                 first_bad;
    logic                 first_lb;
    wsurl_pkg::bracket_e  bracket;
    logic [CW-1:0]        rbr;
    logic [CW-1:0]        path_start;
    logic [16:0]          port_acc;
    logic [2:0]           port_cnt;
  } scan_t;

  scan_t st_q, st_d, stp;

  function automatic logic host_ok(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == "." || c == "-" || c == "_" || c == ":";
  endfunction

  // returns {accumulator, digit count}
  function automatic logic [19:0] port_take(input logic [16:0] acc,
                                            input logic [2:0] cnt,
                                            input logic [7:0] c);
    logic [16:0] a;
    logic [2:0]  n;
    a = acc;
    n = cnt;
    if (cnt != PORT_CNT_BAD) begin
      if (c < "0" || c > "9") begin
        n = PORT_CNT_BAD;
      end else if (cnt >= PORT_CNT_MAX) begin
        n = PORT_CNT_OVER;
      end else begin
        a = (acc << 3) + (acc << 1) + {13'd0, c[3:0]};
        n = cnt + 3'd1;
      end
    end
    return {a, n};
  endfunction

  function automatic logic port_ok(input logic [16:0] acc, input logic [2:0] cnt);
    return cnt >= 3'd1 && cnt <= PORT_CNT_MAX && acc >= 17'd1 && acc <= wsurl_pkg::PORT_MAX;
  endfunction

  // per-byte update
  always_comb begin
    logic [7:0]    c;
    logic [CW-1:0] p;
    logic [CW-1:0] a;
    logic          good;
    logic [2:0]    p3;
    stp  = st_q;
    c    = beat_i.url_char;
    p    = st_q.cnt;
    a    = st_q.auth_len;
    p3   = p[2:0];
    good = 1'b0;
    if (beat_i.has_char) begin
      if (p < CW'(MAX_URL_LEN)) begin
        if (st_q.scheme == wsurl_pkg::SCHEME_MATCH) begin
          case (p3)
            3'd0: good = (c == "w");
            3'd1: good = (c == "s");
            3'd2: begin
              good    = (c == ":" || c == "s");
              stp.tls = (c == "s");
            end
            3'd3: good = st_q.tls ? (c == ":") : (c == "/");
            default: good = (c == "/");
          endcase
          if (!good) begin
            stp.scheme = wsurl_pkg::SCHEME_FAIL;
          end else if (p3 == (stp.tls ? 3'd5 : 3'd4)) begin
            stp.scheme = wsurl_pkg::SCHEME_DONE;
          end
        end else if (st_q.scheme == wsurl_pkg::SCHEME_DONE) begin
          if (st_q.in_path) begin
            if (c == "#") stp.frag = 1'b1;
          end else if (c == "/") begin
            stp.in_path    = 1'b1;
            stp.path_start = p;
          end else begin
            if (a == '0) begin
              stp.first_bad = !host_ok(c);
              stp.first_lb  = (c == "[");
            end
            if (c == ":") stp.colon = 1'b1;
            case (st_q.bracket)
              wsurl_pkg::BR_NONE: begin
                if (c == "]") begin
                  stp.bracket = wsurl_pkg::BR_PENDING;
                  stp.rbr     = a;
                end else begin
                  if (a != '0 && !host_ok(c)) stp.bad_any = 1'b1;
                  if (c == ":") begin
                    stp.last_colon = a;
                    stp.bad_before = stp.bad_any;
                    stp.port_acc   = '0;
                    stp.port_cnt   = '0;
                  end else begin
                    {stp.port_acc, stp.port_cnt} = port_take(st_q.port_acc, st_q.port_cnt, c);
                  end
                end
              end
              wsurl_pkg::BR_PENDING: begin
                if (c == ":") begin
                  stp.bracket  = wsurl_pkg::BR_COLON;
                  stp.port_acc = '0;
                  stp.port_cnt = '0;
                end else begin
                  stp.bracket = wsurl_pkg::BR_OTHER;
                end
              end
              wsurl_pkg::BR_COLON: begin
                {stp.port_acc, stp.port_cnt} = port_take(st_q.port_acc, st_q.port_cnt, c);
              end
              default: begin
              end
            endcase
            stp.auth_len = a + CW'(1);
          end
        end
      end
      if (p <= CW'(MAX_URL_LEN)) stp.cnt = p + CW'(1);
    end
  end

  // verdict on the updated state
  always_comb begin
    logic [CW-1:0] hlen;
    logic          hbad;
    logic          chk;
    logic [3:0]    hoff;
    logic [15:0]   port;
    verdict_o = '0;
    hlen      = '0;
    hbad      = 1'b0;
    chk       = 1'b0;
    hoff      = stp.tls ? 4'd6 : 4'd5;
    port      = stp.tls ? wsurl_pkg::PORT_DEFAULT_WSS : wsurl_pkg::PORT_DEFAULT_WS;
    if (stp.cnt == '0) begin
      verdict_o.status = wsurl_pkg::STATUS_EMPTY;
    end else if (stp.cnt > CW'(MAX_URL_LEN)) begin
      verdict_o.status = wsurl_pkg::STATUS_TOO_LONG;
    end else if (stp.scheme != wsurl_pkg::SCHEME_DONE) begin
      verdict_o.status = wsurl_pkg::STATUS_SCHEME;
    end else begin
      verdict_o.use_tls = stp.tls;
      if (stp.auth_len == '0) begin
        verdict_o.status = wsurl_pkg::STATUS_NO_HOST;
      end else if (stp.frag) begin
        verdict_o.status = wsurl_pkg::STATUS_FRAGMENT;
      end else if (stp.colon && stp.bracket == wsurl_pkg::BR_NONE) begin
        if (!port_ok(stp.port_acc, stp.port_cnt)) begin
          verdict_o.status = wsurl_pkg::STATUS_PORT;
        end else begin
          port = stp.port_acc[15:0];
          hlen = stp.last_colon;
          hbad = stp.first_bad || stp.bad_before;
          chk  = 1'b1;
        end
      end else if (stp.colon) begin
        if (!stp.first_lb) begin
          verdict_o.status = wsurl_pkg::STATUS_BRACKETS;
        end else if (stp.bracket == wsurl_pkg::BR_OTHER) begin
          verdict_o.status = wsurl_pkg::STATUS_JUNK;
        end else if (stp.bracket == wsurl_pkg::BR_COLON &&
                     !port_ok(stp.port_acc, stp.port_cnt)) begin
          verdict_o.status = wsurl_pkg::STATUS_PORT;
        end else begin
          if (stp.bracket == wsurl_pkg::BR_COLON) port = stp.port_acc[15:0];
          hoff = hoff + 4'd1;
          hlen = stp.rbr - CW'(1);
          hbad = stp.bad_any;
          chk  = 1'b1;
        end
      end else begin
        hlen = stp.auth_len;
        hbad = stp.first_bad || stp.bad_any || stp.bracket != wsurl_pkg::BR_NONE;
        chk  = 1'b1;
      end
      if (chk) begin
        if (hlen == '0 || 32'(hlen) > 32'(MAX_HOST_LEN) || hbad) begin
          verdict_o.status = wsurl_pkg::STATUS_BAD_HOST;
        end else begin
          verdict_o.status      = wsurl_pkg::STATUS_OK;
          verdict_o.port_number = port;
          verdict_o.host_offset = 12'(hoff);
          verdict_o.host_length = 8'(hlen);
          if (stp.in_path) begin
            verdict_o.path_given  = 1'b1;
            verdict_o.path_offset = 12'(stp.path_start);
            verdict_o.path_length = 12'(stp.cnt - stp.path_start);
          end
        end
      end
    end
  end

  // start over after each verdict
  always_comb begin
    st_d = st_q;
    if (accept_i) begin
      st_d = beat_i.last_char ? scan_t'('0) : stp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

### rtl/websocket_url_checker.sv
// A verdict is valid in the cycle after the beat that carries last_char is accepted, when
// the result register is free; otherwise it waits in the skid until the result ahead is taken.
// Throughput: one beat per cycle; input stalls only while a verdict sits in the skid.
// A two-entry output (result register plus skid) keeps input ready while a verdict waits.
// Reset clears the scan state and both output valid flags at once; no sweep is needed.
module websocket_url_checker #(
  parameter int MAX_URL_LEN  = wsurl_pkg::MAX_URL_LEN_DEF,
  parameter int MAX_HOST_LEN = wsurl_pkg::MAX_HOST_LEN_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  wsurl_pkg::in_beat_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output wsurl_pkg::out_beat_t out_data_o
);

  wsurl_pkg::out_beat_t verdict;
  wsurl_pkg::out_beat_t out_data_q, out_data_d, skid_data_q, skid_data_d;
  logic                 out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic                 accept, res_new, out_free;

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign res_new    = accept && in_data_i.last_char;
  assign out_free   = !out_valid_q || out_ready_i;

  wsurl_core #(
    .MAX_URL_LEN  (MAX_URL_LEN),
    .MAX_HOST_LEN (MAX_HOST_LEN)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .beat_i    (in_data_i),
    .verdict_o (verdict)
  );

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (out_free) begin
      if (skid_valid_q) begin
        // drain the skid entry; input is held off meanwhile
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else if (res_new) begin
        out_valid_d = 1'b1;
        out_data_d  = verdict;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (res_new) begin
      skid_valid_d = 1'b1;
      skid_data_d  = verdict;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_skid_implies_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without a pending result");

  a_new_result_shown : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_new && !out_valid_q) |=> out_valid_q)
    else $error("verdict lost with output register free");

  a_stall_to_skid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_new && out_valid_q && !out_ready_i) |=> skid_valid_q)
    else $error("verdict not captured in skid during stall");

  a_ok_has_port : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == wsurl_pkg::STATUS_OK) |->
      (out_data_o.port_number != 16'd0 && out_data_o.host_length != 8'd0))
    else $error("accepted URL reports zero port or empty host");
`endif

endmodule

### verif/websocket_url_checker_tb.sv
// Self-checking testbench for the WebSocket URL checker: random and directed URLs, scored verdicts.
module websocket_url_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PORT_DIGITS_MAX = 5;
  localparam int PD_TOO_MANY     = 6;
  localparam int PD_NOT_DIGIT    = 7;
  localparam int RANDOM_CHARS    = 150;
  localparam int RANDOM_URLS     = 15;

  localparam string HOST_SET = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.-_";
  localparam string V6_SET   = "0123456789abcdef:";
  localparam string ODD_SET  = "a1:[]@ %.";
  localparam string PATH_SET = "az09/-._~?=&%#";

  typedef struct packed {
    wsurl_pkg::in_beat_t beat;
    logic                drain_first;
  } pend_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  wsurl_pkg::in_beat_t  in_data = '0;
  logic                 in_ready;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  wsurl_pkg::out_beat_t out_data;

  websocket_url_checker u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Predictor state for the URL in flight.
  int       m_count, m_auth_len, m_last_colon, m_rbr_off, m_path_start, m_port_acc, m_port_digits;
  wsurl_pkg::scheme_e  m_scheme;
  wsurl_pkg::bracket_e m_bracket;
  bit       m_tls, m_in_path, m_frag, m_colon, m_bad_pre_colon, m_bad_any, m_first_bad, m_first_lbr;

  wsurl_pkg::out_beat_t expected_verdicts[$];
  pend_t     beat_q[$];
  logic [7:0] url_buf[$];
  bit        hold_next;
  int        chars_queued, url_count, failures;
  int        send_gap, recv_stall;
  bit        send_eager, recv_eager;
  wsurl_pkg::out_beat_t want;

  task automatic clear_url_state();
    m_count = 0; m_auth_len = 0; m_last_colon = 0; m_rbr_off = 0; m_path_start = 0;
    m_port_acc = 0; m_port_digits = 0;
    m_scheme = wsurl_pkg::SCHEME_MATCH; m_bracket = wsurl_pkg::BR_NONE;
    m_tls = 0; m_in_path = 0; m_frag = 0; m_colon = 0;
    m_bad_pre_colon = 0; m_bad_any = 0; m_first_bad = 0; m_first_lbr = 0;
  endtask

  function automatic bit host_char_ok(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
           c == "." || c == "-" || c == "_" || c == ":";
  endfunction

  task automatic port_restart();
    m_port_acc = 0;
    m_port_digits = 0;
  endtask

  task automatic port_digit(logic [7:0] c);
    if (m_port_digits == PD_NOT_DIGIT) return;
    if (c < "0" || c > "9") begin
      m_port_digits = PD_NOT_DIGIT;
    end else if (m_port_digits >= PORT_DIGITS_MAX) begin
      m_port_digits = PD_TOO_MANY;
    end else begin
      m_port_acc = m_port_acc * 10 + (c - "0");
      m_port_digits++;
    end
  endtask

  function automatic bit port_in_range();
    return m_port_digits >= 1 && m_port_digits <= PORT_DIGITS_MAX &&
           m_port_acc >= 1 && m_port_acc <= int'(wsurl_pkg::PORT_MAX);
  endfunction

  task automatic scheme_char(logic [7:0] c, int p);
    bit good;
    case (p)
      0: good = (c == "w");
      1: good = (c == "s");
      2: begin
        good = (c == ":" || c == "s");
        m_tls = (c == "s");
      end
      3: good = m_tls ? (c == ":") : (c == "/");
      default: good = (c == "/");
    endcase
    if (!good) m_scheme = wsurl_pkg::SCHEME_FAIL;
    else if (p == (m_tls ? 5 : 4)) m_scheme = wsurl_pkg::SCHEME_DONE;
  endtask

  task automatic authority_char(logic [7:0] c);
    int a;
    a = m_auth_len;
    if (a == 0) begin
      m_first_bad = !host_char_ok(c);
      m_first_lbr = (c == "[");
    end
    if (c == ":") m_colon = 1;
    case (m_bracket)
      wsurl_pkg::BR_NONE: begin
        if (c == "]") begin
          m_bracket = wsurl_pkg::BR_PENDING;
          m_rbr_off = a;
        end else begin
          if (a > 0 && !host_char_ok(c)) m_bad_any = 1;
          if (c == ":") begin
            m_last_colon = a;
            m_bad_pre_colon = m_bad_any;
            port_restart();
          end else begin
            port_digit(c);
          end
        end
      end
      wsurl_pkg::BR_PENDING: begin
        if (c == ":") begin
          m_bracket = wsurl_pkg::BR_COLON;
          port_restart();
        end else begin
          m_bracket = wsurl_pkg::BR_OTHER;
        end
      end
      wsurl_pkg::BR_COLON: port_digit(c);
      default: ;
    endcase
    m_auth_len = a + 1;
  endtask

  task automatic scan_char(logic [7:0] c);
    int p;
    p = m_count;
    if (p < wsurl_pkg::MAX_URL_LEN_DEF) begin
      if (m_scheme == wsurl_pkg::SCHEME_MATCH) begin
        scheme_char(c, p);
      end else if (m_scheme == wsurl_pkg::SCHEME_DONE) begin
        if (m_in_path) begin
          if (c == "#") m_frag = 1;
        end else if (c == "/") begin
          m_in_path = 1;
          m_path_start = p;
        end else begin
          authority_char(c);
        end
      end
    end
    // Keep counting one past the limit so the overflow sticks.
    if (p <= wsurl_pkg::MAX_URL_LEN_DEF) m_count = p + 1;
  endtask

  function automatic wsurl_pkg::out_beat_t url_verdict();
    wsurl_pkg::out_beat_t r;
    int          plen, hoff, hlen;
    logic [16:0] port;
    bit          hbad;
    r = '0;
    plen = m_tls ? 6 : 5;
    port = m_tls ? {1'b0, wsurl_pkg::PORT_DEFAULT_WSS} : {1'b0, wsurl_pkg::PORT_DEFAULT_WS};
    hoff = plen;
    if (m_count == 0) begin
      r.status = wsurl_pkg::STATUS_EMPTY;
      return r;
    end
    if (m_count > wsurl_pkg::MAX_URL_LEN_DEF) begin
      r.status = wsurl_pkg::STATUS_TOO_LONG;
      return r;
    end
    if (m_scheme != wsurl_pkg::SCHEME_DONE) begin
      r.status = wsurl_pkg::STATUS_SCHEME;
      return r;
    end
    r.use_tls = m_tls;
    if (m_auth_len == 0) begin
      r.status = wsurl_pkg::STATUS_NO_HOST;
      return r;
    end
    if (m_frag) begin
      r.status = wsurl_pkg::STATUS_FRAGMENT;
      return r;
    end
    if (m_colon && m_bracket == wsurl_pkg::BR_NONE) begin
      if (!port_in_range()) begin
        r.status = wsurl_pkg::STATUS_PORT;
        return r;
      end
      port = m_port_acc[16:0];
      hlen = m_last_colon;
      hbad = m_first_bad || m_bad_pre_colon;
    end else if (m_colon) begin
      if (!m_first_lbr) begin
        r.status = wsurl_pkg::STATUS_BRACKETS;
        return r;
      end
      if (m_bracket == wsurl_pkg::BR_OTHER) begin
        r.status = wsurl_pkg::STATUS_JUNK;
        return r;
      end
      if (m_bracket == wsurl_pkg::BR_COLON) begin
        if (!port_in_range()) begin
          r.status = wsurl_pkg::STATUS_PORT;
          return r;
        end
        port = m_port_acc[16:0];
      end
      hoff = plen + 1;
      hlen = m_rbr_off - 1;
      hbad = m_bad_any;
    end else begin
      hlen = m_auth_len;
      hbad = m_first_bad || m_bad_any || m_bracket != wsurl_pkg::BR_NONE;
    end
    if (hlen <= 0 || hlen > wsurl_pkg::MAX_HOST_LEN_DEF || hbad) begin
      r.status = wsurl_pkg::STATUS_BAD_HOST;
      return r;
    end
    r.status = wsurl_pkg::STATUS_OK;
    r.port_number = port[15:0];
    r.host_offset = 12'(hoff);
    r.host_length = 8'(hlen);
    if (m_in_path) begin
      r.path_given  = 1'b1;
      r.path_offset = 12'(m_path_start);
      r.path_length = 12'(m_count - m_path_start);
    end
    return r;
  endfunction

  task automatic predict_beat(wsurl_pkg::in_beat_t b);
    if (b.has_char) scan_char(b.url_char);
    if (b.last_char) begin
      expected_verdicts.push_back(url_verdict());
      clear_url_state();
    end
  endtask

  // Stimulus builders.
  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) url_buf.push_back(s[i]);
  endtask

  task automatic put_from(string s, int n);
    repeat (n) url_buf.push_back(pick(s));
  endtask

  task automatic put_port();
    case ($urandom_range(0, 9))
      0: put_str("0");
      1: put_str("65535");
      2: put_str("65536");
      3: put_str("99999");
      4: put_str("123456");
      5: ;
      6: put_str("8a");
      7: put_str("00443");
      default: put_str($sformatf("%0d", $urandom_range(1, 65535)));
    endcase
  endtask

  task automatic queue_beat(logic [7:0] c, logic has, logic last);
    pend_t p;
    p.beat.url_char  = c;
    p.beat.has_char  = has;
    p.beat.last_char = last;
    p.drain_first    = hold_next;
    hold_next = 1'b0;
    beat_q.push_back(p);
    if (has) chars_queued++;
  endtask

  task automatic send_url(bit own_end);
    int n;
    n = url_buf.size();
    for (int i = 0; i < n; i++) begin
      // Sprinkle empty beats that the block must ignore.
      if ($urandom_range(0, 15) == 0) queue_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      queue_beat(url_buf[i], 1'b1, !own_end && i == n - 1);
    end
    if (own_end || n == 0) queue_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    url_count++;
  endtask

  task automatic send_str(string s, bit own_end);
    url_buf.delete();
    put_str(s);
    send_url(own_end);
  endtask

  task automatic build_random_url();
    int k;
    url_buf.delete();
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(0, 10)) url_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    put_str($urandom_range(0, 1) ? "wss://" : "ws://");
    case ($urandom_range(0, 5))
      0, 1: put_from(HOST_SET, ($urandom_range(0, 39) == 0) ? $urandom_range(250, 258)
                                                            : $urandom_range(1, 10));
      2: begin
        put_from(HOST_SET, $urandom_range(1, 8));
        put_str(":");
        put_port();
      end
      3: begin
        if ($urandom_range(0, 5) != 0) put_str("[");
        put_from(V6_SET, $urandom_range(0, 8));
        if ($urandom_range(0, 7) == 0) url_buf.push_back(pick(ODD_SET));
        put_str("]");
        if ($urandom_range(0, 5) == 0) url_buf.push_back(pick(HOST_SET));
        if ($urandom_range(0, 1) != 0) begin
          put_str(":");
          put_port();
        end
      end
      4: begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 3) == 0) url_buf.push_back(8'($urandom_range(0, 255)));
          else url_buf.push_back(pick(ODD_SET));
        end
      end
      default: ;
    endcase
    if ($urandom_range(0, 1) != 0) begin
      put_str("/");
      put_from(PATH_SET, $urandom_range(0, 8));
    end
    if ($urandom_range(0, 9) == 0)
      url_buf[$urandom_range(0, url_buf.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 11) == 0) begin
      k = $urandom_range(0, url_buf.size());
      while (url_buf.size() > k) void'(url_buf.pop_back());
    end
  endtask

  // Input driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_beat(in_data);
        if ($urandom_range(0, 99) < 3) send_eager = !send_eager;
        send_gap = send_eager ? 0 : $urandom_range(0, 6);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (beat_q.size() != 0 &&
                     !(beat_q[0].drain_first && expected_verdicts.size() != 0)) begin
          in_data  <= beat_q[0].beat;
          in_valid <= 1'b1;
          void'(beat_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string what, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want_v, got_v);
      failures++;
    end
  endtask

  // Verdict monitor and scoreboard.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected verdict: expected none, actual %h", $time, out_data);
          failures++;
        end else begin
          want = expected_verdicts.pop_front();
          check_field("status", want.status, out_data.status);
          check_field("use_tls", want.use_tls, out_data.use_tls);
          check_field("port_number", want.port_number, out_data.port_number);
          check_field("host_offset", want.host_offset, out_data.host_offset);
          check_field("host_length", want.host_length, out_data.host_length);
          check_field("path_given", want.path_given, out_data.path_given);
          check_field("path_offset", want.path_offset, out_data.path_offset);
          check_field("path_length", want.path_length, out_data.path_length);
        end
        if ($urandom_range(0, 99) < 5) recv_eager = !recv_eager;
        recv_stall = recv_eager ? 0 : $urandom_range(0, 6);
      end
      if (recv_stall > 0) begin
        out_ready <= 1'b0;
        recv_stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int base_chars, base_urls, waited;
    clear_url_state();

    // Directed URLs.
    url_buf.delete();
    send_url(1'b1);                       // empty
    send_str("ws://a", 1'b0);
    send_str("wss://example.org:443/chat", 1'b0);
    send_str("ws://h:65535/", 1'b0);
    send_str("ws://h:0", 1'b0);
    send_str("ws://h:65536", 1'b0);
    send_str("wss://[::1]:8080/x", 1'b0);
    send_str("ws://[fe80::1]", 1'b0);
    send_str("ws://fe80::1]:80", 1'b0);
    send_str("ws://[::1]x", 1'b0);
    send_str("ws://[::1]:", 1'b0);
    send_str("ws:/", 1'b0);
    send_str("wx://a", 1'b0);
    send_str("ws://", 1'b0);
    send_str("ws:///p", 1'b0);
    send_str("ws://a/p#f", 1'b0);
    send_str("ws://a b", 1'b0);
    send_str("ws://a@b:80", 1'b0);
    send_str("wss://b", 1'b1);
    url_buf.delete();
    put_str("ws://a");
    url_buf.push_back(8'h00);
    send_url(1'b0);
    // Host length at the limit and one past.
    url_buf.delete();
    put_str("ws://");
    repeat (wsurl_pkg::MAX_HOST_LEN_DEF) put_str("h");
    send_url(1'b0);
    url_buf.push_back("h");
    send_url(1'b0);

    // Random part; drain now and then so the sender sits idle with nothing in flight.
    hold_next  = 1'b1;
    base_chars = chars_queued;
    base_urls  = url_count;
    while (chars_queued - base_chars < RANDOM_CHARS || url_count - base_urls < RANDOM_URLS) begin
      if (url_count % 10 == 0) hold_next = 1'b1;
      build_random_url();
      send_url($urandom_range(0, 7) == 0);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (beat_q.size() != 0 || in_valid);
    waited = 0;
    while (expected_verdicts.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
    if (expected_verdicts.size() != 0) begin
      $display("%0t: %0d verdicts expected, actual none", $time, expected_verdicts.size());
      failures++;
    end
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
